@@ design/ttx_pes_pkg.sv @@
// Shared types, constants and helpers for the teletext PES line decoder.
`timescale 1ns / 1ps
`default_nettype none

package ttx_pes_pkg;

	// Result kinds
	localparam logic [1:0] KIND_CHAR = 2'd0;
	localparam logic [1:0] KIND_PAGE = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	// Error codes
	localparam logic [1:0] ERR_HDR_LEN  = 2'd0;
	localparam logic [1:0] ERR_STREAM   = 2'd1;
	localparam logic [1:0] ERR_LINE_LEN = 2'd2;

	// Stream constants
	localparam logic [7:0] START_ID     = 8'hBD;
	localparam logic [7:0] HDR_DATA_LEN = 8'h24;
	localparam logic [7:0] SID_MIN      = 8'h10;
	localparam logic [7:0] SID_MAX      = 8'h1F;
	localparam logic [7:0] LINE_LEN     = 8'd44;
	localparam logic [7:0] LINE_FEED    = 8'h0A;
	localparam logic [5:0] LINE_LAST    = 6'd45;
	localparam logic [5:0] SKIP_LAST    = 6'd35;
	localparam logic [3:0] MAG_WRAP     = 4'd8;

	// Division by 46 of a 17-bit value: multiply by ceil(2^22/46) and shift.
	localparam logic [16:0] DIV46_MUL   = 17'd91181;
	localparam int          DIV46_SHIFT = 22;

	localparam int RES_FIFO_DEPTH = 4;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] char_code;
		logic [9:0] page_number;
		logic [1:0] error_code;
		logic       last;
	} result_t;

	// Bits 0,2,4,6 of a byte become bits 3,2,1,0 of a nibble.
	function automatic logic [3:0] ham_nibble(input logic [7:0] b);
		return {b[0], b[2], b[4], b[6]};
	endfunction

	localparam logic [7:0] CHAR_MAP [256] = '{
		8'h20,8'h20,8'h20,8'h20,8'h20,8'hA0,8'h60,8'hE0,
		8'h10,8'h90,8'h20,8'h50,8'h30,8'h30,8'h70,8'hF0,
		8'h08,8'h88,8'h48,8'h48,8'h28,8'h28,8'h68,8'hE8,
		8'h18,8'h98,8'h58,8'h58,8'h38,8'hB8,8'h78,8'h78,
		8'h20,8'h84,8'h44,8'h44,8'h24,8'hA4,8'h64,8'h71,
		8'h14,8'h94,8'h54,8'hD4,8'h34,8'hB4,8'h74,8'h74,
		8'h0C,8'h8C,8'h4C,8'h4C,8'h20,8'hAC,8'h6C,8'h6C,
		8'h1C,8'h9C,8'h5C,8'hDC,8'h3C,8'h3C,8'hF6,8'h20,
		8'h20,8'h82,8'h20,8'h42,8'h22,8'h27,8'h62,8'hE2,
		8'h12,8'h92,8'h52,8'hD2,8'h32,8'hB2,8'h72,8'h72,
		8'h42,8'h20,8'h4A,8'hCA,8'h2A,8'h6A,8'h6A,8'h4A,
		8'h1A,8'h9A,8'h5A,8'h5A,8'h3A,8'h3A,8'h7A,8'hFA,
		8'h06,8'h20,8'h46,8'hC6,8'h26,8'hA6,8'h66,8'h66,
		8'h16,8'h96,8'h56,8'h56,8'h36,8'h36,8'h76,8'h20,
		8'h0E,8'h8E,8'h4E,8'h4E,8'h2E,8'h2E,8'h6E,8'hEE,
		8'h1E,8'h9E,8'h5E,8'hDE,8'h3E,8'hBE,8'h7E,8'hDF,
		8'h20,8'h20,8'h41,8'h41,8'h21,8'h21,8'h61,8'hE1,
		8'h11,8'h91,8'h51,8'hD1,8'h31,8'hB1,8'h71,8'h63,
		8'h09,8'h89,8'h49,8'hC9,8'h29,8'hA9,8'h69,8'h69,
		8'h19,8'h99,8'h59,8'h59,8'h39,8'h39,8'h79,8'hF9,
		8'h05,8'h70,8'h45,8'hC5,8'h25,8'h70,8'hE9,8'h65,
		8'h15,8'h95,8'h55,8'h55,8'h35,8'h35,8'h75,8'h20,
		8'h20,8'h8D,8'h4D,8'h4D,8'h2D,8'h2D,8'h6D,8'hED,
		8'h1D,8'h20,8'hDC,8'hDD,8'h3D,8'h63,8'h7D,8'hFC,
		8'h03,8'h20,8'h43,8'h43,8'h23,8'hA3,8'h71,8'h63,
		8'h13,8'h93,8'h53,8'h53,8'h33,8'h33,8'h73,8'hF3,
		8'h20,8'h8B,8'h4B,8'h4B,8'h2B,8'h2B,8'h6B,8'hEB,
		8'h1B,8'h9B,8'h5B,8'hDB,8'h3B,8'hBB,8'h7B,8'hE4,
		8'h20,8'h87,8'h47,8'h47,8'h27,8'h27,8'h67,8'hE7,
		8'h17,8'h20,8'h57,8'h57,8'h37,8'hB7,8'h77,8'h77,
		8'h0F,8'h8F,8'h4F,8'hCF,8'h2F,8'hAF,8'hF3,8'h6F,
		8'h1F,8'h9F,8'h20,8'hDF,8'h3F,8'h3F,8'h20,8'h20
	};

endpackage

`default_nettype wire

@@ design/ttx_pes_res_fifo.sv @@
// Result queue: takes up to two results per cycle, hands out one per word.
`timescale 1ns / 1ps
`default_nettype none

module ttx_pes_res_fifo import ttx_pes_pkg::*; #(
	parameter int Depth = RES_FIFO_DEPTH
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic [1:0] push_n,
	input  wire result_t push_a,
	input  wire result_t push_b,
	output logic         space_ok,
	output logic         out_valid,
	input  wire logic    out_stall,
	output result_t      out_res
);

	localparam int PW = $clog2(Depth);
	localparam int CW = $clog2(Depth + 1);

	result_t        mem [Depth];
	logic [PW-1:0]  wr_q;
	logic [PW-1:0]  rd_q;
	logic [CW-1:0]  count_q;
	logic           pop;

	assign out_valid = (count_q != '0);
	assign pop       = out_valid && !out_stall;
	assign space_ok  = (count_q <= CW'(Depth - 2));
	assign out_res   = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem[wr_q] <= push_a;
		end
		if (push_n == 2'd2) begin
			mem[PW'(wr_q + 1'b1)] <= push_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= PW'(wr_q + PW'(push_n));
			rd_q    <= PW'(rd_q + PW'(pop));
			count_q <= CW'(count_q + CW'(push_n) - CW'(pop));
		end
	end

endmodule

`default_nettype wire

@@ design/teletext_pes_line_decoder.sv @@
// Top level of the teletext PES line decoder: byte parser and result queue.
//
// Channel   Direction  Handshake            Word
// input     in         in_valid / in_stall  data_byte
// output    out        out_valid/out_stall  kind, char_code, page_number, error_code, last
//
// A byte is taken into an input register and parsed from there, one byte per
// cycle unless stalled. Its zero, one or two results go into a small result queue,
// so one result leaves per cycle unless out_stall is high; only the last character
// of a line gives two. The input stalls only while the queue has fewer than two
// free entries. Reset returns the parser to the start code hunt and empties the queue.
`timescale 1ns / 1ps
`default_nettype none

module teletext_pes_line_decoder import ttx_pes_pkg::*; #(
	parameter int ResDepth = RES_FIFO_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] data_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [1:0]      kind,
	output logic [7:0]      char_code,
	output logic [9:0]      page_number,
	output logic [1:0]      error_code,
	output logic            last
);

	typedef enum logic [2:0] {
		PH_HUNT, PH_HDR, PH_SKIP, PH_SID, PH_LINE, PH_DRAIN
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [1:0]  sync_q, sync_d;
	logic [5:0]  idx_q, idx_d;
	logic [15:0] plen_q, plen_d;
	logic [10:0] lines_q, lines_d;
	logic [3:0]  mag_q, mag_d;
	logic [3:0]  row_q, row_d;
	logic [3:0]  units_q, units_d;
	logic [9:0]  page_q, page_d;
	logic [3:0]  hund_q, hund_d;
	logic        pend_q, pend_d;
	logic [11:0] quot_q;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        space_ok;
	logic        advance;

	logic [1:0]  push_n;
	result_t     res_a, res_b, out_res;

	logic [16:0] plen6;
	logic [33:0] prod;
	logic [2:0]  mag_raw;
	logic [3:0]  row_new;
	logic [7:0]  low;

	assign advance  = valid_s1 && space_ok;
	assign in_stall = valid_s1 && !space_ok;

	// Line count is (length + 6) / 46 less three, the quotient refreshed every cycle;
	// the length settles long before the stream id byte uses it.
	assign plen6 = {1'b0, plen_q} + 17'd6;
	assign prod  = plen6 * DIV46_MUL;

	always_comb begin
		phase_d = phase_q;
		sync_d  = sync_q;
		idx_d   = idx_q;
		plen_d  = plen_q;
		lines_d = lines_q;
		mag_d   = mag_q;
		row_d   = row_q;
		units_d = units_q;
		page_d  = page_q;
		hund_d  = hund_q;
		pend_d  = pend_q;
		push_n  = 2'd0;
		res_a   = '{kind: KIND_CHAR, char_code: 8'd0, page_number: page_q,
			error_code: ERR_HDR_LEN, last: 1'b0};
		res_b   = res_a;
		mag_raw = {byte_s1[2], byte_s1[4], byte_s1[6]};
		row_new = row_q | ham_nibble(byte_s1);
		low     = 8'(ham_nibble(byte_s1) * 8'd10) + {4'd0, units_q};
		case (phase_q)
			PH_HDR: begin
				if (idx_q == 6'd0) begin
					plen_d = {byte_s1, 8'h00};
				end else if (idx_q == 6'd1) begin
					plen_d = {plen_q[15:8], byte_s1};
				end
				if (idx_q >= 6'd4) begin
					if (byte_s1 != HDR_DATA_LEN) begin
						push_n           = 2'd1;
						res_a.kind       = KIND_ERR;
						res_a.error_code = ERR_HDR_LEN;
						phase_d          = PH_HUNT;
						sync_d           = 2'd0;
						idx_d            = 6'd0;
					end else begin
						phase_d = PH_SKIP;
						idx_d   = 6'd0;
					end
				end else begin
					idx_d = idx_q + 6'd1;
				end
			end
			PH_SKIP: begin
				if (idx_q >= SKIP_LAST) begin
					phase_d = PH_SID;
					idx_d   = 6'd0;
				end else begin
					idx_d = idx_q + 6'd1;
				end
			end
			PH_SID: begin
				if (byte_s1 < SID_MIN || byte_s1 > SID_MAX) begin
					push_n           = 2'd1;
					res_a.kind       = KIND_ERR;
					res_a.error_code = ERR_STREAM;
					phase_d          = PH_HUNT;
					sync_d           = 2'd0;
					idx_d            = 6'd0;
				end else begin
					lines_d = (quot_q > 12'd3) ? 11'(quot_q - 12'd3) : 11'd0;
					if (quot_q <= 12'd3) begin
						phase_d = PH_HUNT;
						sync_d  = 2'd0;
						idx_d   = 6'd0;
					end else begin
						phase_d = PH_LINE;
						idx_d   = 6'd0;
					end
				end
			end
			PH_LINE: begin
				if (idx_q == 6'd1 && byte_s1 != LINE_LEN) begin
					push_n           = 2'd1;
					res_a.kind       = KIND_ERR;
					res_a.error_code = ERR_LINE_LEN;
					phase_d          = PH_DRAIN;
					idx_d            = 6'd2;
				end else begin
					if (idx_q == 6'd4) begin
						mag_d = (mag_raw == 3'd0) ? MAG_WRAP : {1'b0, mag_raw};
						row_d = {3'd0, byte_s1[0]};
					end else if (idx_q == 6'd5) begin
						row_d = row_new;
						if (row_new == 4'd0 && pend_q) begin
							push_n     = 2'd1;
							res_a.kind = KIND_PAGE;
							pend_d     = 1'b0;
						end
					end else if (idx_q == 6'd6) begin
						if (row_q == 4'd0) begin
							units_d = ham_nibble(byte_s1);
						end
					end else if (idx_q == 6'd7 && row_q == 4'd0) begin
						// The hundreds digit is kept beside the page number so the
						// magazine match needs no division.
						page_d = 10'(10'(mag_q) * 10'd100) + {2'd0, low};
						hund_d = mag_q + {3'd0, (low >= 8'd100)};
					end
					if (idx_q >= 6'd7 && row_q != 4'd0 && mag_q == hund_q) begin
						push_n          = 2'd1;
						res_a.char_code = CHAR_MAP[byte_s1];
						pend_d          = 1'b1;
						if (idx_q == LINE_LAST) begin
							push_n          = 2'd2;
							res_b.char_code = LINE_FEED;
						end
					end
					if (idx_q >= LINE_LAST) begin
						idx_d   = 6'd0;
						lines_d = lines_q - 11'd1;
						if (lines_q == 11'd1) begin
							phase_d = PH_HUNT;
							sync_d  = 2'd0;
						end
					end else begin
						idx_d = idx_q + 6'd1;
					end
				end
			end
			PH_DRAIN: begin
				if (idx_q >= LINE_LAST) begin
					phase_d = PH_HUNT;
					sync_d  = 2'd0;
					idx_d   = 6'd0;
				end else begin
					idx_d = idx_q + 6'd1;
				end
			end
			default: begin
				phase_d = PH_HUNT;
				if (sync_q == 2'd3) begin
					if (byte_s1 == START_ID) begin
						phase_d = PH_HDR;
						idx_d   = 6'd0;
						sync_d  = 2'd0;
					end else begin
						sync_d = (byte_s1 == 8'd0) ? 2'd1 : 2'd0;
					end
				end else if (byte_s1 == 8'd0) begin
					sync_d = (sync_q >= 2'd2) ? 2'd2 : sync_q + 2'd1;
				end else if (byte_s1 == 8'd1 && sync_q == 2'd2) begin
					sync_d = 2'd3;
				end else begin
					sync_d = 2'd0;
				end
			end
		endcase
		if (push_n == 2'd1) begin
			res_a.last = 1'b1;
		end else if (push_n == 2'd2) begin
			res_b.last = 1'b1;
		end
		if (!advance) begin
			push_n = 2'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= data_byte;
		end
		quot_q <= prod[DIV46_SHIFT +: 12];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_q  <= PH_HUNT;
			sync_q   <= 2'd0;
			idx_q    <= 6'd0;
			plen_q   <= 16'd0;
			lines_q  <= 11'd0;
			mag_q    <= 4'd0;
			row_q    <= 4'd0;
			units_q  <= 4'd0;
			page_q   <= 10'd0;
			hund_q   <= 4'd0;
			pend_q   <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				phase_q <= phase_d;
				sync_q  <= sync_d;
				idx_q   <= idx_d;
				plen_q  <= plen_d;
				lines_q <= lines_d;
				mag_q   <= mag_d;
				row_q   <= row_d;
				units_q <= units_d;
				page_q  <= page_d;
				hund_q  <= hund_d;
				pend_q  <= pend_d;
			end
		end
	end

	ttx_pes_res_fifo #(
		.Depth(ResDepth)
	) u_res_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.push_a    (res_a),
		.push_b    (res_b),
		.space_ok  (space_ok),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res)
	);

	assign kind        = out_res.kind;
	assign char_code   = out_res.char_code;
	assign page_number = out_res.page_number;
	assign error_code  = out_res.error_code;
	assign last        = out_res.last;

	// A held input word stays in the input register until the queue has room.
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !space_ok |=> valid_s1 && $stable(byte_s1))
		else $error("held input word lost or changed");

	// A pending page is only closed by pushing its page complete word.
	a_page_close: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(pend_q) |-> $past(push_n) == 2'd1 && $past(res_a.kind) == KIND_PAGE)
		else $error("pending page dropped without a page complete word");

	// Draining a bad line always starts past the length byte and ends at its last byte.
	a_drain_idx: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DRAIN |-> idx_q >= 6'd2 && idx_q <= LINE_LAST)
		else $error("line drain index out of range");

endmodule

`default_nettype wire

@@ sim/teletext_pes_line_decoder_test.sv @@
// Self-checking testbench for the teletext PES line decoder, with its result scoreboard.
`timescale 1ns / 1ps

import ttx_pes_pkg::*;

localparam int SKIP_BYTES = 36;
localparam int LINE_BYTES = 46;
localparam logic [1:0] ERR_NONE = 2'd0;

// Character translation, entry 0 in the top byte.
localparam logic [2047:0] GLYPH_TABLE = {
	128'h20202020_20A060E0_10902050_303070F0,
	128'h08884848_282868E8_18985858_38B87878,
	128'h20844444_24A46471_149454D4_34B47474,
	128'h0C8C4C4C_20AC6C6C_1C9C5CDC_3C3CF620,
	128'h20822042_222762E2_129252D2_32B27272,
	128'h42204ACA_2A6A6A4A_1A9A5A5A_3A3A7AFA,
	128'h062046C6_26A66666_16965656_36367620,
	128'h0E8E4E4E_2E2E6EEE_1E9E5EDE_3EBE7EDF,
	128'h20204141_212161E1_119151D1_31B17163,
	128'h098949C9_29A96969_19995959_393979F9,
	128'h057045C5_2570E965_15955555_35357520,
	128'h208D4D4D_2D2D6DED_1D20DCDD_3D637DFC,
	128'h03204343_23A37163_13935353_333373F3,
	128'h208B4B4B_2B2B6BEB_1B9B5BDB_3BBB7BE4,
	128'h20874747_272767E7_17205757_37B77777,
	128'h0F8F4FCF_2FAFF36F_1F9F20DF_3F3F2020
};

class teletext_result_board;
	typedef enum logic [2:0] {ST_HUNT, ST_HDR, ST_SKIP, ST_SID, ST_LINE, ST_DRAIN} parse_t;

	parse_t      state;
	logic [1:0]  zeros;
	logic [5:0]  idx;
	logic [15:0] pkt_len;
	logic [10:0] lines_left;
	logic [3:0]  mag;
	logic [4:0]  row;
	logic [3:0]  units;
	logic [9:0]  page;
	logic        page_open;
	result_t     due[$];
	int          mismatches;

	function new();
		hunt();
		pkt_len = '0;
		lines_left = '0;
		mag = '0;
		row = '0;
		units = '0;
		page = '0;
		page_open = 1'b0;
		mismatches = 0;
	endfunction

	function void hunt();
		state = ST_HUNT;
		zeros = '0;
		idx = '0;
	endfunction

	// Hamming-protected nibble: bits 0,2,4,6 carry nibble bits 3,2,1,0.
	function logic [3:0] row_nibble(logic [7:0] b);
		return {b[0], b[2], b[4], b[6]};
	endfunction

	function void emit(logic [1:0] k, logic [7:0] ch, logic [1:0] err);
		result_t r;
		r.kind = k;
		r.char_code = ch;
		r.page_number = page;
		r.error_code = err;
		r.last = 1'b0;
		due.push_back(r);
	endfunction

	function int pending();
		return due.size();
	endfunction

	// Advances the parser by one accepted word and queues the results it causes.
	function void parse_byte(logic [7:0] d);
		int first;
		int q;
		first = due.size();
		case (state)
			ST_HDR: begin
				if (idx == 6'd0) pkt_len = {d, 8'h00};
				else if (idx == 6'd1) pkt_len[7:0] = d;
				if (idx >= 6'd4) begin
					if (d != HDR_DATA_LEN) begin
						emit(KIND_ERR, 8'h00, ERR_HDR_LEN);
						hunt();
					end else begin
						state = ST_SKIP;
						idx = '0;
					end
				end else begin
					idx = idx + 6'd1;
				end
			end
			ST_SKIP: begin
				idx = idx + 6'd1;
				if (int'(idx) >= SKIP_BYTES) begin
					state = ST_SID;
					idx = '0;
				end
			end
			ST_SID: begin
				if (d < SID_MIN || d > SID_MAX) begin
					emit(KIND_ERR, 8'h00, ERR_STREAM);
					hunt();
				end else begin
					q = (int'(pkt_len) + 6) / LINE_BYTES;
					lines_left = (q > 3) ? 11'(q - 3) : 11'd0;
					if (lines_left == 11'd0) begin
						hunt();
					end else begin
						state = ST_LINE;
						idx = '0;
					end
				end
			end
			ST_LINE: begin
				if (idx == 6'd1 && d != LINE_LEN) begin
					emit(KIND_ERR, 8'h00, ERR_LINE_LEN);
					state = ST_DRAIN;
					idx = 6'd2;
				end else begin
					if (idx == 6'd4) begin
						mag = {1'b0, d[2], d[4], d[6]};
						if (mag == 4'd0) mag = 4'd8;
						row = {4'd0, d[0]};
					end else if (idx == 6'd5) begin
						row = row | {1'b0, row_nibble(d)};
						if (row == 5'd0 && page_open) begin
							emit(KIND_PAGE, 8'h00, ERR_NONE);
							page_open = 1'b0;
						end
					end else if (idx == 6'd6) begin
						if (row == 5'd0) units = row_nibble(d);
					end else if (idx == 6'd7 && row == 5'd0) begin
						page = 10'(100 * int'(mag) + 10 * int'(row_nibble(d)) + int'(units));
					end
					if (idx >= 6'd7 && row != 5'd0 && int'(mag) == int'(page) / 100) begin
						emit(KIND_CHAR, GLYPH_TABLE[8 * (255 - int'(d)) +: 8], ERR_NONE);
						page_open = 1'b1;
						if (int'(idx) == LINE_BYTES - 1) emit(KIND_CHAR, LINE_FEED, ERR_NONE);
					end
					if (int'(idx) >= LINE_BYTES - 1) begin
						idx = '0;
						lines_left = lines_left - 11'd1;
						if (lines_left == 11'd0) hunt();
					end else begin
						idx = idx + 6'd1;
					end
				end
			end
			ST_DRAIN: begin
				if (int'(idx) >= LINE_BYTES - 1) hunt();
				else idx = idx + 6'd1;
			end
			default: begin
				state = ST_HUNT;
				if (zeros == 2'd3) begin
					if (d == START_ID) begin
						state = ST_HDR;
						idx = '0;
						zeros = '0;
					end else begin
						zeros = (d == 8'h00) ? 2'd1 : 2'd0;
					end
				end else if (d == 8'h00) begin
					zeros = (zeros >= 2'd2) ? 2'd2 : zeros + 2'd1;
				end else if (d == 8'h01 && zeros == 2'd2) begin
					zeros = 2'd3;
				end else begin
					zeros = '0;
				end
			end
		endcase
		if (due.size() > first) due[due.size() - 1].last = 1'b1;
	endfunction

	task report(input string what);
		if (mismatches < 30) $display("mismatch: %s", what);
		mismatches++;
	endtask

	task check(input result_t got);
		result_t want;
		if (due.size() == 0) begin
			report($sformatf("unexpected result kind %0d char %02h page %0d err %0d last %0d",
				got.kind, got.char_code, got.page_number, got.error_code, got.last));
			return;
		end
		want = due.pop_front();
		if (got.kind !== want.kind || got.char_code !== want.char_code ||
				got.page_number !== want.page_number || got.error_code !== want.error_code ||
				got.last !== want.last)
			report($sformatf({"got kind %0d char %02h page %0d err %0d last %0d, ",
				"want %0d %02h %0d %0d %0d"},
				got.kind, got.char_code, got.page_number, got.error_code, got.last,
				want.kind, want.char_code, want.page_number, want.error_code, want.last));
	endtask
endclass

module teletext_pes_line_decoder_test;
	localparam int CYCLE_LIMIT = 400000;
	localparam int ITEM_TARGET = 1700;

	typedef enum {PKT_GOOD, PKT_SHORT, PKT_BAD_HDR, PKT_BAD_SID, PKT_BAD_LINE} pkt_form_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] data_byte = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [1:0] kind;
	logic [7:0] char_code;
	logic [9:0] page_number;
	logic [1:0] error_code;
	logic       last;

	teletext_result_board board = new();
	bit tx_burst = 1'b0;
	bit rx_burst = 1'b0;
	bit rx_holding = 1'b0;
	int bytes_sent = 0;
	int cycle_count = 0;

	teletext_pes_line_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.char_code(char_code),
		.page_number(page_number),
		.error_code(error_code),
		.last(last)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic logic [7:0] rand_byte();
		return 8'($urandom());
	endfunction

	// Places a nibble on the protected bit positions, odd bits random.
	function automatic logic [7:0] spread_bits(input logic [3:0] n);
		logic [7:0] b;
		b = rand_byte();
		b[0] = n[3];
		b[2] = n[2];
		b[4] = n[1];
		b[6] = n[0];
		return b;
	endfunction

	// Offers one word and returns at the edge where it is taken.
	task automatic send_byte(input logic [7:0] d);
		int gap;
		gap = (tx_burst || rx_holding) ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= d;
		do @(posedge clk); while (in_stall);
		board.parse_byte(d);
		bytes_sent++;
	endtask

	// Idles the input and waits until every expected result has come out, so the next word is driven in a later step.
	task automatic wait_all_out();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0) @(posedge clk);
	endtask

	task automatic send_line(input logic [3:0] mag, input bit header, input bit bad_len);
		logic [3:0] row_nib;
		logic       row_lsb;
		logic [7:0] b;
		send_byte(rand_byte());
		if (bad_len) begin
			do b = rand_byte(); while (b == LINE_LEN);
			send_byte(b);
			repeat (LINE_BYTES - 2) send_byte(rand_byte());
			return;
		end
		send_byte(LINE_LEN);
		send_byte(rand_byte());
		send_byte(rand_byte());
		if (header) begin
			row_lsb = 1'b0;
			row_nib = 4'd0;
		end else begin
			row_lsb = 1'($urandom_range(0, 1));
			row_nib = 4'($urandom_range(0, 15));
			if (!row_lsb && row_nib == 4'd0) row_nib = 4'd1;
		end
		send_byte(spread_bits({row_lsb, mag[2:0]}));
		send_byte(spread_bits(row_nib));
		if (header) begin
			send_byte(spread_bits(4'($urandom_range(0, 15))));
			// Tens above nine push the page past its magazine's hundred.
			if ($urandom_range(0, 4) == 0) send_byte(spread_bits(4'($urandom_range(10, 15))));
			else send_byte(spread_bits(4'($urandom_range(0, 9))));
			repeat (LINE_BYTES - 8) send_byte(rand_byte());
		end else begin
			repeat (LINE_BYTES - 6) send_byte(rand_byte());
		end
	endtask

	task automatic send_packet(input pkt_form_t form);
		int          n_lines;
		int          bad_line;
		int          i;
		logic [15:0] plen;
		logic [3:0]  mag;
		logic [3:0]  line_mag;
		logic [7:0]  b;
		bit          header;
		tx_burst = ($urandom_range(0, 3) == 0);
		n_lines = $urandom_range(1, 3);
		bad_line = $urandom_range(0, n_lines - 1);
		plen = 16'(LINE_BYTES * (n_lines + 3) - 6 + $urandom_range(0, LINE_BYTES - 1));
		if (form == PKT_SHORT)
			plen = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(0, 177));
		else if (form == PKT_BAD_LINE && $urandom_range(0, 1) == 1)
			plen = 16'hFFFF;
		send_byte(8'h00);
		send_byte(8'h00);
		if ($urandom_range(0, 3) == 0) send_byte(8'h00);
		send_byte(8'h01);
		send_byte(START_ID);
		send_byte(plen[15:8]);
		send_byte(plen[7:0]);
		send_byte(rand_byte());
		send_byte(rand_byte());
		if (form == PKT_BAD_HDR) begin
			do b = rand_byte(); while (b == HDR_DATA_LEN);
			send_byte(b);
			return;
		end
		send_byte(HDR_DATA_LEN);
		repeat (SKIP_BYTES) send_byte(rand_byte());
		if (form == PKT_BAD_SID) begin
			do b = rand_byte(); while (b >= SID_MIN && b <= SID_MAX);
			send_byte(b);
			return;
		end
		send_byte(8'($urandom_range(SID_MIN, SID_MAX)));
		if (form == PKT_SHORT) return;
		mag = 4'($urandom_range(1, 8));
		for (i = 0; i < n_lines; i++) begin
			header = (i == 0) ? ($urandom_range(0, 99) < 85) : ($urandom_range(0, 99) < 15);
			line_mag = ($urandom_range(0, 99) < 85) ? mag : 4'($urandom_range(1, 8));
			send_line(line_mag, header, form == PKT_BAD_LINE && i == bad_line);
			if (form == PKT_BAD_LINE && i == bad_line) return;
		end
	endtask

	initial begin : stimulus
		logic [7:0] opening[$];
		int         pick;
		int         packets;
		packets = 0;
		// Extremes, a start code behind three zeros and two broken headers.
		opening = '{8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h01, START_ID,
			8'hFF, 8'hFF, 8'h00, 8'h00, 8'h23,
			8'h00, 8'h00, 8'h01, 8'h01,
			8'h00, 8'h00, 8'h01, START_ID, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (opening[k]) send_byte(opening[k]);
		wait_all_out();
		while (bytes_sent < ITEM_TARGET) begin
			if (packets == 8) wait_all_out();
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				tx_burst = 1'b0;
				repeat ($urandom_range(1, 12)) send_byte(rand_byte());
			end else if (pick < 16) send_packet(PKT_BAD_HDR);
			else if (pick < 24) send_packet(PKT_BAD_SID);
			else if (pick < 34) send_packet(PKT_BAD_LINE);
			else if (pick < 40) send_packet(PKT_SHORT);
			else send_packet(PKT_GOOD);
			packets++;
		end
		wait_all_out();
		repeat (16) @(posedge clk);
		if (board.mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin : result_sink
		int      hold;
		int      seen;
		result_t got;
		hold = 0;
		seen = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				got = '{kind, char_code, page_number, error_code, last};
				board.check(got);
				seen++;
				if (seen % 40 == 0) rx_burst = ($urandom_range(0, 3) == 0);
				// One long hold-off lets the result queue fill and back up the input.
				if (seen == 120) begin
					hold = 300;
					rx_holding = 1'b1;
				end else begin
					hold = rx_burst ? 0 : $urandom_range(0, 14);
				end
				if (hold > 0) out_stall <= 1'b1;
			end else if (hold > 0) begin
				hold--;
				if (hold == 0) begin
					out_stall <= 1'b0;
					rx_holding = 1'b0;
				end
			end
		end
	end
endmodule
